[hw/rtl/mp2d_pkg.sv]
// Shared types and constants for the streaming 2-D max pooling block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mp2d_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int MaxChannels = 4;
  localparam int MaxWindow   = 8;
  localparam int MaxStep     = 8;

  localparam int AddrBits  = 5;
  localparam int StoreBits = 13;   // {row mod 8, column, channel}

  // register indexes
  localparam logic [2:0] RegWidth   = 3'd0;
  localparam logic [2:0] RegHeight  = 3'd1;
  localparam logic [2:0] RegChans   = 3'd2;
  localparam logic [2:0] RegWindow  = 3'd3;
  localparam logic [2:0] RegStep    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  // effective (clamped) geometry
  typedef struct packed {
    logic [8:0] w;
    logic [8:0] h;
    logic [2:0] c;
    logic [3:0] k;
    logic [3:0] s;
  } geom_t;

  typedef struct packed {
    logic load;   // take a sample, advance the raster position
    logic rd;     // read running maximum of current window
    logic wr;     // write back updated maximum
    logic emit;   // load the output register
    logic step;   // move to next window
  } cmd_t;

  typedef struct packed {
    logic empty;     // sample at the live position touches no window
    logic ends;      // current window completes with this sample
    logic last_win;  // current window is the last one for this sample
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

[hw/rtl/mp2d_ctrl.sv]
// Sequencer for the max pooling block: walks the windows touched by a sample.
// Depends on mp2d_pkg.
`timescale 1ns / 1ps
module mp2d_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mp2d_pkg::stat_t stat,
  output mp2d_pkg::cmd_t  cmd
);
  import mp2d_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !stat.empty) state_next = ST_READ;
      end
      ST_READ: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!stat.ends || stat.out_free) begin
          state_next = stat.last_win ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ: cmd.rd = 1'b1;
      ST_UPDATE: begin
        if (!stat.ends || stat.out_free) begin
          cmd.wr   = 1'b1;
          cmd.emit = stat.ends;
          cmd.step = !stat.last_win;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/mp2d_datapath.sv]
// Datapath: raster position, window range counters, running-maximum store
// and output register. Depends on mp2d_pkg.
`timescale 1ns / 1ps
module mp2d_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  mp2d_pkg::geom_t      geom,
  input  logic                 restart,
  input  mp2d_pkg::cmd_t       cmd,
  output mp2d_pkg::stat_t      stat,
  input  logic signed [15:0]   sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [14:0]          max_value,
  output logic [7:0]           out_row,
  output logic [7:0]           out_col,
  output logic [1:0]           channel,
  output logic                 last_of_run
);
  import mp2d_pkg::*;

  // live raster position and window ranges
  logic [7:0] pos_col, pos_row;
  logic [1:0] pos_chan;
  logic [8:0] rmin, cmin;
  logic [7:0] rmax, cmax;
  logic [2:0] rmod, cmod;

  // latched sample context
  logic [7:0]  w_r, w_c, w_rmin, w_cmin, w_rmax, w_cmax;
  logic [1:0]  w_ch;
  logic [14:0] w_v;
  logic        w_lastrow, w_lastcol;

  logic [7:0]  orow, ocol;
  logic [14:0] rdata;
  logic [14:0] store [2**StoreBits];

  logic        chan_wrap, col_wrap, row_wrap;
  logic [13:0] cmin_lim, rmin_lim;
  logic [11:0] r0, c0;
  logic        first, row_end, col_end, last_res;
  logic [14:0] m;
  logic [StoreBits-1:0] addr;
  logic        out_take;

  assign chan_wrap = (3'(pos_chan) + 3'd1) >= geom.c;
  assign col_wrap  = (9'(pos_col) + 9'd1) >= geom.w;
  assign row_wrap  = (9'(pos_row) + 9'd1) >= geom.h;
  assign cmin_lim  = 14'(cmin) * 14'(geom.s) + 14'(geom.k);
  assign rmin_lim  = 14'(rmin) * 14'(geom.s) + 14'(geom.k);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_col <= '0; pos_row <= '0; pos_chan <= '0;
      rmin <= '0; rmax <= '0; rmod <= '0;
      cmin <= '0; cmax <= '0; cmod <= '0;
    end else if (cmd.load) begin
      if (!chan_wrap) begin
        pos_chan <= pos_chan + 2'd1;
      end else begin
        pos_chan <= '0;
        if (!col_wrap) begin
          pos_col <= pos_col + 8'd1;
          if (4'(cmod) + 4'd1 == geom.s) begin
            cmod <= '0;
            cmax <= cmax + 8'd1;
          end else begin
            cmod <= cmod + 3'd1;
          end
          if (cmin_lim <= 14'(pos_col) + 14'd1) cmin <= cmin + 9'd1;
        end else begin
          pos_col <= '0;
          cmin <= '0; cmax <= '0; cmod <= '0;
          if (!row_wrap) begin
            pos_row <= pos_row + 8'd1;
            if (4'(rmod) + 4'd1 == geom.s) begin
              rmod <= '0;
              rmax <= rmax + 8'd1;
            end else begin
              rmod <= rmod + 3'd1;
            end
            if (rmin_lim <= 14'(pos_row) + 14'd1) rmin <= rmin + 9'd1;
          end else begin
            pos_row <= '0;
            rmin <= '0; rmax <= '0; rmod <= '0;
          end
        end
      end
    end
  end

  // sample context and window walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r       <= pos_row;
      w_c       <= pos_col;
      w_ch      <= pos_chan;
      w_v       <= sample[15] ? 15'd0 : sample[14:0];
      w_rmin    <= rmin[7:0];
      w_cmin    <= cmin[7:0];
      w_rmax    <= rmax;
      w_cmax    <= cmax;
      w_lastrow <= (9'(pos_row) + 9'd1) == geom.h;
      w_lastcol <= (9'(pos_col) + 9'd1) == geom.w;
      orow      <= rmin[7:0];
      ocol      <= cmin[7:0];
    end else if (cmd.step) begin
      if (ocol == w_cmax) begin
        ocol <= w_cmin;
        orow <= orow + 8'd1;
      end else begin
        ocol <= ocol + 8'd1;
      end
    end
  end

  assign r0      = 12'(orow) * 12'(geom.s);
  assign c0      = 12'(ocol) * 12'(geom.s);
  assign first   = (r0 == 12'(w_r)) && (c0 == 12'(w_c));
  assign row_end = w_lastrow || (r0 + 12'(geom.k) == 12'(w_r) + 12'd1);
  assign col_end = w_lastcol || (c0 + 12'(geom.k) == 12'(w_c) + 12'd1);
  // only the lowest window can end early; on the image edge all of them end
  assign last_res = (orow == (w_lastrow ? w_rmax : w_rmin))
                 && (ocol == (w_lastcol ? w_cmax : w_cmin));
  assign m    = (first || w_v > rdata) ? w_v : rdata;
  assign addr = {orow[2:0], ocol, w_ch};

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= store[addr];
    if (cmd.wr) store[addr] <= m;
  end

  // output register
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      max_value   <= m;
      out_row     <= orow;
      out_col     <= ocol;
      channel     <= w_ch;
      last_of_run <= last_res;
    end
  end

  assign stat.empty    = (rmin > 9'(rmax)) || (cmin > 9'(cmax));
  assign stat.ends     = row_end && col_end;
  assign stat.last_win = (orow == w_rmax) && (ocol == w_cmax);
  assign stat.out_free = !out_valid || !out_stall;

endmodule

[hw/rtl/max_pool_2d_stream_core.sv]
// Top level of the streaming 2-D max pooling block: register port,
// sequencer and datapath. Depends on mp2d_pkg, mp2d_ctrl, mp2d_datapath.
`timescale 1ns / 1ps
// Samples arrive in raster order (channel fastest, then column, then row),
// one transfer each. Every sample updates the running maximum, floored at
// zero, of each window that covers it; when a window's last sample arrives
// the maximum goes out with its output row, column and channel, and
// last_of_run marks the final result of that sample. Each sample is loaded,
// then the single-port maximum store is read and written back for each of the
// N windows covering it (up to 64 with window 8 and step 1); in_stall holds
// off the next sample until the last window is done. A stalled result holds
// the walk only when a further result is due. Registers: width, height,
// channels, window, step at byte offsets 0x00..0x10; zero counts as one and
// field values above the limit saturate. Any register write restarts the
// raster at row 0, column 0, channel 0. The store needs no clearing after
// reset: each entry is loaded by its window's first sample.
module max_pool_2d_stream_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mp2d_pkg::AddrBits-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [14:0]                    max_value,
  output logic [7:0]                     out_row,
  output logic [7:0]                     out_col,
  output logic [1:0]                     channel,
  output logic                           last_of_run
);
  import mp2d_pkg::*;

  logic [8:0] img_width, img_height;
  logic [2:0] channel_count;
  logic [3:0] window_size, step_size;
  logic       wr_en, restart;
  logic [2:0] idx;
  geom_t      geom;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width     <= 9'd8;
      img_height    <= 9'd8;
      channel_count <= 3'd3;
      window_size   <= 4'd2;
      step_size     <= 4'd2;
    end else if (wr_en) begin
      case (idx)
        RegWidth:  img_width     <= pwdata[8:0];
        RegHeight: img_height    <= pwdata[8:0];
        RegChans:  channel_count <= pwdata[2:0];
        RegWindow: window_size   <= pwdata[3:0];
        RegStep:   step_size     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // writes to unused offsets leave the raster position alone
  assign restart = wr_en && (idx == RegWidth || idx == RegHeight || idx == RegChans
                          || idx == RegWindow || idx == RegStep);

  always_comb begin
    case (idx)
      RegWidth:  prdata = 32'(img_width);
      RegHeight: prdata = 32'(img_height);
      RegChans:  prdata = 32'(channel_count);
      RegWindow: prdata = 32'(window_size);
      RegStep:   prdata = 32'(step_size);
      default:   prdata = '0;
    endcase
  end

  // clamped geometry: zero as one, saturate at the limits
  always_comb begin
    geom.w = (img_width == '0) ? 9'd1 : (img_width > 9'(MaxWidth)) ? 9'(MaxWidth)
           : img_width;
    geom.h = (img_height == '0) ? 9'd1 : (img_height > 9'(MaxHeight)) ? 9'(MaxHeight)
           : img_height;
    geom.c = (channel_count == '0) ? 3'd1
           : (channel_count > 3'(MaxChannels)) ? 3'(MaxChannels) : channel_count;
    geom.k = (window_size == '0) ? 4'd1
           : (window_size > 4'(MaxWindow)) ? 4'(MaxWindow) : window_size;
    geom.s = (step_size == '0) ? 4'd1
           : (step_size > 4'(MaxStep)) ? 4'(MaxStep) : step_size;
  end

  mp2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mp2d_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .restart     (restart),
    .cmd         (cmd),
    .stat        (stat),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .max_value   (max_value),
    .out_row     (out_row),
    .out_col     (out_col),
    .channel     (channel),
    .last_of_run (last_of_run)
  );

endmodule

[hw/rtl/mp2d_checker.sv]
// Port-level checks for the max pooling block, bound to the top level.
// Depends on mp2d_pkg.
`timescale 1ns / 1ps
module mp2d_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [mp2d_pkg::AddrBits-1:0] paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [14:0]                   max_value,
  input logic [7:0]                    out_row,
  input logic [7:0]                    out_col,
  input logic [1:0]                    channel,
  input logic                          last_of_run
);
  import mp2d_pkg::*;

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(out_row)
      && $stable(out_col) && $stable(channel) && $stable(last_of_run))
    else $error("stalled result changed");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[4:2] == RegWidth)
      ##1 (psel && !pwrite && paddr[4:2] == RegWidth)
      |-> prdata[8:0] == $past(pwdata[8:0]))
    else $error("width register readback mismatch");

endmodule

bind max_pool_2d_stream_core mp2d_checker u_mp2d_checker (
  .clk         (clk),
  .rst         (rst),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .max_value   (max_value),
  .out_row     (out_row),
  .out_col     (out_col),
  .channel     (channel),
  .last_of_run (last_of_run)
);
